@@ sv/dotg_pkg.sv @@
// dotg_pkg: constants, widths and month table for the day offset to date unit
// no dependencies

`timescale 1ns / 1ps

package dotg_pkg;

    localparam int OFFSET_BITS_DEF = 24;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int DOY_W   = 9;
    localparam int WDAY_W  = 3;

    localparam int EPOCH_DAYS  = -577734;
    localparam int DAYS_400Y   = 365 * 400 + 100 - 3;
    localparam int DAYS_100Y   = 365 * 100 + 25 - 1;
    localparam int DAYS_4Y     = 365 * 4 + 1;
    localparam int DAYS_1Y     = 365;
    localparam int DAYS_WEEK   = 7;
    // 1 jan of year 1 counted from 1 mar of year 0
    localparam int MARCH_SHIFT = 306;
    localparam int DAYS_JAN_FEB = 59;

    // day within the 400-year era and its derived widths
    localparam int DOE_W  = 18;
    localparam int REM_W  = 20;
    localparam int YOE_W  = 9;
    localparam int MP_W   = 4;
    localparam int ERA_SH = 17;

    // month index counted from march
    localparam logic [MP_W-1:0] MP_JAN      = 4'd10;
    localparam logic [MP_W-1:0] MP_TO_MONTH = 4'd3;
    localparam logic [MP_W-1:0] MP_WRAP     = 4'd9;
    localparam int              MONTHS      = 12;

    // exact reciprocals for 18-bit dividends
    localparam int RCP_W    = 19;
    localparam int PROD_W   = DOE_W + RCP_W;
    localparam int SH_1460  = 29;
    localparam int SH_36524 = 34;
    localparam int SH_7     = 21;
    localparam int SH_365   = 27;

    localparam logic [RCP_W-1:0] RCP_1460 =
        RCP_W'(((longint'(1) << SH_1460) + longint'(DAYS_4Y - 2)) / longint'(DAYS_4Y - 1));
    localparam logic [RCP_W-1:0] RCP_36524 =
        RCP_W'(((longint'(1) << SH_36524) + longint'(DAYS_100Y - 1)) / longint'(DAYS_100Y));
    localparam logic [RCP_W-1:0] RCP_7 =
        RCP_W'(((longint'(1) << SH_7) + longint'(DAYS_WEEK - 1)) / longint'(DAYS_WEEK));
    localparam logic [RCP_W-1:0] RCP_365 =
        RCP_W'(((longint'(1) << SH_365) + longint'(DAYS_1Y - 1)) / longint'(DAYS_1Y));

    // first day of each month counted from 1 mar
    function automatic logic [DOY_W-1:0] mar_month_start(input logic [MP_W-1:0] idx);
        logic [DOY_W-1:0] res;
        case (idx)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

@@ sv/dotg_req_if.sv @@
// dotg_req_if: request channel carrying a signed day offset
// depends on dotg_pkg

`timescale 1ns / 1ps

interface dotg_req_if #(
    parameter int OFFSET_BITS = dotg_pkg::OFFSET_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [OFFSET_BITS-1:0] day_offset;

    modport source (output valid, output day_offset, input ready);
    modport sink   (input valid, input day_offset, output ready);
endinterface

@@ sv/dotg_res_if.sv @@
// dotg_res_if: result channel carrying the calendar date fields
// depends on dotg_pkg

`timescale 1ns / 1ps

interface dotg_res_if;
    import dotg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DOM_W-1:0]         day_of_month;
    logic [DOY_W-1:0]         day_of_year;
    logic [WDAY_W-1:0]        weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output day_of_year, output weekday, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input day_of_year, input weekday, output ready);
endinterface

@@ sv/day_offset_to_gregorian_date_unit.sv @@
// Converts a signed day offset from 14 Oct 1582 into the proleptic Gregorian
// year, month, day of month, day of year and weekday (1 is Sunday). The unit is a
// pipeline of eleven registers: a request is taken in every cycle unless the result
// side stalls, and the constant-reciprocal divisions (400-year era, years within the
// era) and the month search are spread over the stages. Stages hold their data and
// close bubbles when the result side stalls. The year wraps to its low 16 bits; all
// other fields are exact for any OFFSET_BITS.
// depends on dotg_pkg, dotg_req_if, dotg_res_if

`timescale 1ns / 1ps

module day_offset_to_gregorian_date_unit #(
    parameter int OFFSET_BITS = dotg_pkg::OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dotg_req_if.sink     i_req,
    dotg_res_if.source   o_res
);
    import dotg_pkg::*;

    localparam int ZW    = OFFSET_BITS + 2;
    localparam int AW    = ZW - ERA_SH;
    localparam int NWORK = 10;
    localparam int LAST  = NWORK;

    // bias keeps the day count non-negative for the era division
    localparam longint NB = ((longint'(1) << (OFFSET_BITS - 1)) + longint'(DAYS_400Y) - 1)
                            / longint'(DAYS_400Y);
    localparam logic [ZW-1:0] ZOFS =
        ZW'(NB * longint'(DAYS_400Y) + longint'(MARCH_SHIFT) - longint'(EPOCH_DAYS));
    localparam logic [YEAR_W-1:0] NB16  = YEAR_W'(NB);
    localparam logic [AW-1:0]     R_ERA = AW'((longint'(1) << ZW) / longint'(DAYS_400Y));
    localparam logic [DOE_W-1:0]  D400  = DOE_W'(DAYS_400Y);
    localparam logic [DOE_W-1:0]  D400M = DOE_W'(DAYS_400Y - 1);
    localparam logic [REM_W-1:0]  D400R = REM_W'(DAYS_400Y);
    localparam logic [REM_W-1:0]  D800R = REM_W'(2 * DAYS_400Y);

    typedef struct packed {
        logic signed [OFFSET_BITS-1:0] ofs;
        logic [ZW-1:0]                 zb;
        logic [AW-1:0]                 qe;
        logic [REM_W-1:0]              rem;
        logic [DOE_W-1:0]              doe;
        logic [YEAR_W-1:0]             era;
        logic [6:0]                    q1460;
        logic [2:0]                    q36524;
        logic                          top;
        logic [14:0]                   q7;
        logic [YEAR_W-1:0]             y400;
        logic [DOE_W-1:0]              t;
        logic [WDAY_W-1:0]             wd;
        logic [YOE_W-1:0]              yoe;
        logic [DOY_W-1:0]              doy;
        logic [MP_W-1:0]               mp;
    } t_work;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   dom;
        logic [DOY_W-1:0]   doy;
        logic [WDAY_W-1:0]  wd;
    } t_res;

    t_work            r_pipe [NWORK];
    t_work            n_pipe [NWORK];
    t_res             r_res;
    t_res             n_res;
    logic [LAST:0]    r_vld;
    logic [LAST:0]    en;

    logic [2*AW-1:0]    s2_prod;
    logic [AW+17:0]     s3_qd;
    logic               s4_ge1;
    logic               s4_ge2;
    logic [PROD_W-1:0]  s5_p1460;
    logic [PROD_W-1:0]  s5_p36524;
    logic [DOE_W-1:0]   s5_doe3;
    logic [PROD_W-1:0]  s5_p7;
    logic [DOE_W-1:0]   s6_doe3;
    logic [DOE_W-1:0]   s6_q7x7;
    logic [DOE_W-1:0]   s6_wrem;
    logic [PROD_W-1:0]  s7_p365;
    logic [DOE_W-1:0]   s8_sub;
    logic [DOE_W-1:0]   s8_doy;
    logic [1:0]         s8_c100;
    logic [MP_W-1:0]    s9_cnt;
    logic               s10_jf;
    logic [YOE_W-1:0]   s10_ty;
    logic               s10_leap;
    logic [DOY_W-1:0]   s10_dom;

    // stall chain: a stage moves when it is empty or the next one moves
    always_comb begin
        en[LAST] = !r_vld[LAST] || o_res.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_req.ready = en[0];

    assign s2_prod   = r_pipe[1].zb[ZW-1:ERA_SH] * R_ERA;
    assign s3_qd     = r_pipe[2].qe * D400;
    assign s4_ge2    = r_pipe[3].rem >= D800R;
    assign s4_ge1    = r_pipe[3].rem >= D400R;
    assign s5_p1460  = r_pipe[4].doe * RCP_1460;
    assign s5_p36524 = r_pipe[4].doe * RCP_36524;
    assign s5_doe3   = r_pipe[4].doe + DOE_W'(3);
    assign s5_p7     = s5_doe3 * RCP_7;
    assign s6_doe3   = r_pipe[5].doe + DOE_W'(3);
    assign s6_q7x7   = r_pipe[5].q7 * DOE_W'(DAYS_WEEK);
    assign s6_wrem   = s6_doe3 - s6_q7x7;
    assign s7_p365   = r_pipe[6].t * RCP_365;
    assign s8_c100   = 2'(r_pipe[7].yoe >= YOE_W'(100)) + 2'(r_pipe[7].yoe >= YOE_W'(200))
                     + 2'(r_pipe[7].yoe >= YOE_W'(300));
    assign s8_sub    = r_pipe[7].yoe * DOE_W'(DAYS_1Y) + DOE_W'(r_pipe[7].yoe >> 2)
                     - DOE_W'(s8_c100);
    assign s8_doy    = r_pipe[7].doe - s8_sub;

    always_comb begin
        s9_cnt = '0;
        for (int k = 1; k < MONTHS; k++) begin
            if (r_pipe[8].doy >= mar_month_start(MP_W'(k))) begin
                s9_cnt = s9_cnt + MP_W'(1);
            end
        end
    end

    assign s10_jf   = r_pipe[9].mp >= MP_JAN;
    assign s10_ty   = r_pipe[9].yoe + YOE_W'(s10_jf);
    assign s10_leap = (s10_ty[1:0] == 2'd0) && (s10_ty != YOE_W'(100))
                   && (s10_ty != YOE_W'(200)) && (s10_ty != YOE_W'(300));
    assign s10_dom  = r_pipe[9].doy - mar_month_start(r_pipe[9].mp) + DOY_W'(1);

    always_comb begin
        n_pipe[0]     = r_pipe[0];
        n_pipe[0].ofs = i_req.day_offset;
        for (int k = 1; k < NWORK; k++) begin
            n_pipe[k] = r_pipe[k-1];
        end

        // rebase to days since 1 mar of year 0, biased non-negative
        n_pipe[1].zb = ZW'(r_pipe[0].ofs) + ZOFS;

        // era estimate from the upper bits, low by at most two
        n_pipe[2].qe = s2_prod[2*AW-1:AW];

        n_pipe[3].rem = r_pipe[2].zb[REM_W-1:0] - s3_qd[REM_W-1:0];

        if (s4_ge2) begin
            n_pipe[4].doe = DOE_W'(r_pipe[3].rem - D800R);
            n_pipe[4].era = YEAR_W'(r_pipe[3].qe) + YEAR_W'(2) - NB16;
        end else if (s4_ge1) begin
            n_pipe[4].doe = DOE_W'(r_pipe[3].rem - D400R);
            n_pipe[4].era = YEAR_W'(r_pipe[3].qe) + YEAR_W'(1) - NB16;
        end else begin
            n_pipe[4].doe = DOE_W'(r_pipe[3].rem);
            n_pipe[4].era = YEAR_W'(r_pipe[3].qe) - NB16;
        end

        n_pipe[5].q1460  = s5_p1460[SH_1460 +: 7];
        n_pipe[5].q36524 = s5_p36524[SH_36524 +: 3];
        n_pipe[5].top    = r_pipe[4].doe == D400M;
        n_pipe[5].q7     = s5_p7[SH_7 +: 15];
        n_pipe[5].y400   = r_pipe[4].era * YEAR_W'(400);

        n_pipe[6].t  = r_pipe[5].doe - DOE_W'(r_pipe[5].q1460) + DOE_W'(r_pipe[5].q36524)
                     - DOE_W'(r_pipe[5].top);
        n_pipe[6].wd = s6_wrem[WDAY_W-1:0] + WDAY_W'(1);

        n_pipe[7].yoe = s7_p365[SH_365 +: YOE_W];

        n_pipe[8].doy = s8_doy[DOY_W-1:0];

        n_pipe[9].mp = s9_cnt;

        n_res.year  = r_pipe[9].y400 + YEAR_W'(r_pipe[9].yoe) + YEAR_W'(s10_jf);
        n_res.month = s10_jf ? MONTH_W'(r_pipe[9].mp - MP_WRAP)
                             : MONTH_W'(r_pipe[9].mp + MP_TO_MONTH);
        n_res.dom   = s10_dom[DOM_W-1:0];
        n_res.doy   = s10_jf ? r_pipe[9].doy - DOY_W'(MARCH_SHIFT - 1)
                             : r_pipe[9].doy + DOY_W'(DAYS_JAN_FEB + 1) + DOY_W'(s10_leap);
        n_res.wd    = r_pipe[9].wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NWORK; k++) begin
            if (en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
        if (en[LAST]) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_vld[LAST];
    assign o_res.year         = signed'(r_res.year);
    assign o_res.month        = r_res.month;
    assign o_res.day_of_month = r_res.dom;
    assign o_res.day_of_year  = r_res.doy;
    assign o_res.weekday      = r_res.wd;

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for day_offset_to_gregorian_date_unit, with a date predictor,
// calendar edge cases, random offsets under varied idling and a long result-side stall
// depends on dotg_pkg, dotg_req_if, dotg_res_if and the unit itself

`timescale 1ns / 1ps

module tb_top;
    import dotg_pkg::*;

    localparam int OFS_W        = OFFSET_BITS_DEF;
    localparam int PIPE_LATENCY = 11;
    localparam int LONG_HOLD    = 80;
    localparam int LIMIT_CYCLES = 200000;

    typedef logic signed [OFS_W-1:0] offset_t;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DOM_W-1:0]         day_of_month;
        logic [DOY_W-1:0]         day_of_year;
        logic [WDAY_W-1:0]        weekday;
    } date_t;

    localparam int DAYS_BEFORE_MONTH [MONTHS] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic i_clk;
    logic i_rst_n;

    dotg_req_if #(.OFFSET_BITS(OFS_W)) req_if ();
    dotg_res_if                        res_if ();

    day_offset_to_gregorian_date_unit #(.OFFSET_BITS(OFS_W)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    date_t pending_dates[$];
    int    mismatch_count = 0;
    int    send_idle_pct  = 0;
    int    stall_pct      = 0;
    int    hold_seq       = 0;
    int    hold_seen      = 0;
    int    hold_left      = 0;
    int    cycle_count    = 0;

    // ---------------------------------------------------------------- calendar arithmetic

    function automatic longint quot_down(input longint a, input longint b);
        if (a >= 0)
            return a / b;
        return -((-a - 1) / b) - 1;
    endfunction

    function automatic bit is_leap(input longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // offset of 1 jan of year y
    function automatic longint jan1_day(input longint y);
        longint p;
        p = y - 1;
        return longint'(EPOCH_DAYS) + 365 * p + quot_down(p, 4) - quot_down(p, 100)
               + quot_down(p, 400);
    endfunction

    function automatic date_t date_of_offset(input offset_t ofs_in);
        longint ofs, d0, n400, r1, n100, r2, n4, r3, n1, y;
        longint jan1, yday, march1, corr, m, dom, wd;
        bit     lp;
        date_t  d;
        ofs  = ofs_in;
        d0   = ofs - longint'(EPOCH_DAYS);
        n400 = quot_down(d0, DAYS_400Y);
        r1   = d0 - n400 * DAYS_400Y;
        n100 = r1 / DAYS_100Y;
        r2   = r1 - n100 * DAYS_100Y;
        n4   = r2 / DAYS_4Y;
        r3   = r2 - n4 * DAYS_4Y;
        n1   = r3 / DAYS_1Y;
        y    = 400 * n400 + 100 * n100 + 4 * n4 + n1;
        // last day of a 400- or 4-year cycle stays in the closing year
        if (n100 != 4 && n1 != 4)
            y++;
        lp     = is_leap(y);
        jan1   = jan1_day(y);
        yday   = ofs - jan1 + 1;
        march1 = jan1 + DAYS_JAN_FEB + (lp ? 1 : 0);
        corr   = (ofs < march1) ? 0 : (lp ? 1 : 2);
        m      = (12 * (yday - 1 + corr) + 373) / 367;
        if (m < 1)
            m = 1;
        if (m > MONTHS)
            m = MONTHS;
        dom = yday - DAYS_BEFORE_MONTH[m - 1] - ((m >= 3 && lp) ? 1 : 0);
        wd  = (d0 + 1) % DAYS_WEEK;
        if (wd < 0)
            wd += DAYS_WEEK;
        wd += 1;
        d.year         = YEAR_W'(y);
        d.month        = MONTH_W'(m);
        d.day_of_month = DOM_W'(dom);
        d.day_of_year  = DOY_W'(yday);
        d.weekday      = WDAY_W'(wd);
        return d;
    endfunction

    // ---------------------------------------------------------------- clock, reset, watchdog

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge i_clk) cycle_count++;
        $display("tb_top: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- result side

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen    <= hold_seq;
            hold_left    <= LONG_HOLD;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        date_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_dates.size() == 0) begin
                $error("result with no pending request: year %0d", $signed(res_if.year));
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                check_field("year", want.year, res_if.year);
                check_field("month", want.month, res_if.month);
                check_field("day_of_month", want.day_of_month, res_if.day_of_month);
                check_field("day_of_year", want.day_of_year, res_if.day_of_year);
                check_field("weekday", want.weekday, res_if.weekday);
            end
        end
    end

    // ---------------------------------------------------------------- request side

    task automatic send_day(input offset_t ofs);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.day_offset <= ofs;
        do @(posedge i_clk); while (!req_if.ready);
        pending_dates.push_back(date_of_offset(ofs));
    endtask

    task automatic drain_pending();
        req_if.valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic offset_t rand_offset();
        longint y;
        int     doy;
        case ($urandom_range(3))
            0: return offset_t'($urandom);
            1: begin
                // around year ends and the end of february
                y = longint'($urandom_range(45000)) - 21000;
                case ($urandom_range(2))
                    0: doy = $urandom_range(1, 3);
                    1: doy = $urandom_range(58, 62);
                    default: doy = $urandom_range(364, 366);
                endcase
                return offset_t'(jan1_day(y) + doy - 1);
            end
            2: return offset_t'(longint'($urandom_range(4000)) - 2000
                                + ($urandom_range(1) ? longint'(EPOCH_DAYS) : 0));
            default: begin
                if ($urandom_range(1))
                    return offset_t'({1'b0, {(OFS_W-1){1'b1}}} - $urandom_range(500));
                return offset_t'({1'b1, {(OFS_W-1){1'b0}}} + $urandom_range(500));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_calendar_edges();
        longint years [12] = '{1, 0, 0, -100, -400, -1, 1600, 1700, 1700, 1900, 2000, 2000};
        int     doys  [12] = '{1, 366, 60, 60, 366, 365, 60, 59, 60, 365, 366, 60};
        send_idle_pct = 0;
        stall_pct    <= 0;
        send_day(offset_t'(0));
        send_day(offset_t'(1));
        send_day(offset_t'(-1));
        send_day({1'b0, {(OFS_W-1){1'b1}}});
        send_day({1'b1, {(OFS_W-1){1'b0}}});
        send_day(offset_t'(24'h555555));
        send_day(offset_t'(24'hAAAAAA));
        send_day(offset_t'(EPOCH_DAYS));
        send_day(offset_t'(EPOCH_DAYS - 1));
        for (int i = 0; i < 12; i++)
            send_day(offset_t'(jan1_day(years[i]) + doys[i] - 1));
        drain_pending();
    endtask

    task automatic test_random_dates(input int idle_pct, input int stall, input int n);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        for (int i = 0; i < n; i++)
            send_day(rand_offset());
        drain_pending();
    endtask

    // result side held off long enough for the pipeline to fill and stall requests
    task automatic test_input_stall();
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_seq     <= hold_seq + 1;
        for (int i = 0; i < 40; i++)
            send_day(rand_offset());
        drain_pending();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.day_offset <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_calendar_edges();
        test_random_dates(0, 0, 170);
        test_random_dates(69, 0, 170);
        test_random_dates(0, 69, 170);
        test_random_dates(35, 35, 170);
        test_input_stall();

        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
